// ===== rtl/ptst_pkg.sv =====
// Package for the periodic timer slot table.
// Field widths, action and status codes, and the control/status structs.
// No dependencies.
package ptst_pkg;

  localparam int unsigned ActionW    = 3;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned ValW       = 16;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntNW      = $clog2(MaxResults);

  // Action codes
  localparam logic [ActionW-1:0] ACT_TICK     = 3'd0;
  localparam logic [ActionW-1:0] ACT_REGISTER = 3'd1;
  localparam logic [ActionW-1:0] ACT_DELETE   = 3'd2;
  localparam logic [ActionW-1:0] ACT_MODIFY   = 3'd3;
  localparam logic [ActionW-1:0] ACT_EXECUTE  = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK     = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL   = 3'd1;
  localparam logic [StatusW-1:0] ST_BADIDX = 3'd2;
  localparam logic [StatusW-1:0] ST_FIRED  = 3'd3;
  localparam logic [StatusW-1:0] ST_NONE   = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch request fields, rewind scan
    logic tick_run;   // tick scan: read slot, write back previous
    logic adv;        // step scan index
    logic reg_claim;  // claim current slot and emit
    logic exec_fire;  // fire current slot and emit
    logic resp_emit;  // emit single closing result
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_end;    // scan index past last slot
    logic tick_busy;  // tick write-back stage occupied
    logic cur_free;   // current slot unused
    logic cur_fire;   // current slot valid and pending
    logic fire_any;   // some slot valid and pending
    logic exec_last;  // current firing is the final one
    logic out_free;   // output register can take a result
  } dp_status_t;

endpackage

// ===== rtl/ptst_req_if.sv =====
// Request channel of the periodic timer slot table.
// Depends on ptst_pkg.
interface ptst_req_if;
  import ptst_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [SlotW-1:0]   slot_index;
  logic [ValW-1:0]    delay_value;
  logic [ValW-1:0]    reload_value;

  modport source (
    output valid, action, slot_index, delay_value, reload_value,
    input  ready
  );
  modport sink (
    input  valid, action, slot_index, delay_value, reload_value,
    output ready
  );
endinterface

// ===== rtl/ptst_rsp_if.sv =====
// Result channel of the periodic timer slot table.
// Depends on ptst_pkg.
interface ptst_rsp_if;
  import ptst_pkg::*;

  logic               valid;
  logic               ready;
  logic [SlotW-1:0]   slot_out;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (
    output valid, slot_out, status, last,
    input  ready
  );
  modport sink (
    input  valid, slot_out, status, last,
    output ready
  );
endinterface

// ===== rtl/periodic_timer_slot_table.sv =====
// Top level of the periodic timer slot table (tick-based task scheduler).
// Depends on ptst_pkg, ptst_req_if, ptst_rsp_if, ptst_ctrl, ptst_datapath.
//
// Usage notes:
//  - req_i carries one request: action, slot_index, delay_value,
//    reload_value. rsp_o returns results: slot_out, status, last. Both are
//    valid/ready; a transfer happens when both are high on a clock edge.
//  - One request is worked at a time; ready is high only while the
//    sequencer is idle. Each request yields one or more results, the final
//    one flagged by last.
//  - Work per request (result not stalled):
//      tick            every slot, one slot per cycle through the countdown
//                      memory, one write-back stage, then the result
//      register        up to the first free slot, all slots when full
//      execute         up to the highest fired slot, one cycle per slot scanned;
//                      only the result when nothing is pending
//      delete, modify  only the result
//  - Execute returns at most 16 results; slots beyond stay pending.
//  - A single output register decouples the sides: a new request is taken
//    while the previous final result still waits. If the receiver stalls,
//    the scan holds on the slot to be reported until the register frees.
//  - Reset clears every valid and pending mark; countdown and period
//    memories are not cleared, as a slot is written before it is used.
module periodic_timer_slot_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptst_req_if.sink    req_i,
  ptst_rsp_if.source  rsp_o
);
  import ptst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  // sequencer
  ptst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .st_i         (dp_st),
    .cmd_o        (cmd)
  );

  // slot table, scan and output register
  ptst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (dp_st),
    .action_i       (req_i.action),
    .slot_index_i   (req_i.slot_index),
    .delay_value_i  (req_i.delay_value),
    .reload_value_i (req_i.reload_value),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .slot_out_o     (rsp_o.slot_out),
    .status_o       (rsp_o.status),
    .last_o         (rsp_o.last)
  );

  // at most one result loaded per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.reg_claim, cmd.exec_fire, cmd.resp_emit}))
    else $error("more than one result loaded in a cycle");

  // a claim lands on a free slot and never overwrites a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reg_claim |-> (dp_st.cur_free && dp_st.out_free))
    else $error("register claimed a busy slot or overran the output");

  // a fired slot was pending, and the output had room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec_fire |-> (dp_st.cur_fire && dp_st.out_free))
    else $error("execute fired a slot that was not pending");

  // tick write-back only follows a tick read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_st.tick_busy |-> $past(cmd.tick_run))
    else $error("tick write-back without a tick scan");

endmodule

// ===== rtl/ptst_ctrl.sv =====
// Sequencing state machine of the periodic timer slot table.
// Depends on ptst_pkg; drives ptst_datapath through ctrl_cmd_t.
module ptst_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [ptst_pkg::ActionW-1:0] req_action_i,
  output logic                         req_ready_o,
  input  ptst_pkg::dp_status_t         st_i,
  output ptst_pkg::ctrl_cmd_t          cmd_o
);
  import ptst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TICK = 5'b00010,
    S_REG  = 5'b00100,
    S_EXEC = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          case (req_action_i)
            ACT_TICK:     state_d = S_TICK;
            ACT_REGISTER: state_d = S_REG;
            ACT_EXECUTE:  state_d = st_i.fire_any ? S_EXEC : S_RESP;
            default:      state_d = S_RESP;
          endcase
        end
      end
      S_TICK: begin
        cmd_o.tick_run = 1'b1;
        cmd_o.adv      = !st_i.idx_end;
        if (st_i.idx_end && !st_i.tick_busy) begin
          state_d = S_RESP;
        end
      end
      S_REG: begin
        if (st_i.idx_end) begin
          state_d = S_RESP;
        end else if (st_i.cur_free) begin
          if (st_i.out_free) begin
            cmd_o.reg_claim = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_EXEC: begin
        if (st_i.idx_end) begin
          state_d = S_IDLE;
        end else if (st_i.cur_fire) begin
          if (st_i.out_free) begin
            cmd_o.exec_fire = 1'b1;
            if (st_i.exec_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.resp_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ptst_datapath.sv =====
// Slot table datapath: valid/pending flags, countdown and period memories,
// scan index, tick write-back stage and output register. Depends on ptst_pkg.
module ptst_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptst_pkg::ctrl_cmd_t          cmd_i,
  output ptst_pkg::dp_status_t         st_o,
  input  logic [ptst_pkg::ActionW-1:0] action_i,
  input  logic [ptst_pkg::SlotW-1:0]   slot_index_i,
  input  logic [ptst_pkg::ValW-1:0]    delay_value_i,
  input  logic [ptst_pkg::ValW-1:0]    reload_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ptst_pkg::SlotW-1:0]   slot_out_o,
  output logic [ptst_pkg::StatusW-1:0] status_o,
  output logic                         last_o
);
  import ptst_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0]  SlotsC  = CntW'(SLOTS);
  localparam logic [SlotW:0]   SlotsW  = (SlotW + 1)'(SLOTS);
  localparam logic [CntNW-1:0] LastN   = CntNW'(MaxResults - 1);

  // request latch
  logic [ActionW-1:0] act_q;
  logic [SlotW-1:0]   sidx_q;
  logic [ValW-1:0]    delay_q, reload_q;

  // scan state
  logic [CntW-1:0]  idx_q;
  logic [CntNW-1:0] n_q;
  logic [IdxW-1:0]  cur;

  // per-slot flags
  logic [SLOTS-1:0] valid_q, pend_q, pzero_q;
  logic [SLOTS-1:0] fire_vec, above;

  // memories
  logic [ValW-1:0] cd_mem [SLOTS];
  logic [ValW-1:0] pr_mem [SLOTS];
  logic [ValW-1:0] cd_rd_q, pr_rd_q;

  // tick write-back stage
  logic            s1_valid_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [ValW-1:0] cd_dec, cd_new;
  logic            cd_hit, tick_wr;

  // misc
  logic            idx_end, bad_idx, emit, out_free;
  logic [IdxW-1:0] sidx;
  logic [SlotW-1:0]   res_slot;
  logic [StatusW-1:0] res_status;
  logic               res_last;

  logic               out_valid_q, out_last_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [StatusW-1:0] out_status_q;

  assign cur      = idx_q[IdxW-1:0];
  assign sidx     = sidx_q[IdxW-1:0];
  assign idx_end  = (idx_q == SlotsC);
  assign bad_idx  = ({1'b0, sidx_q} >= SlotsW);
  assign fire_vec = valid_q & pend_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (CntW'(j) > idx_q);
    end
  end

  assign st_o.idx_end   = idx_end;
  assign st_o.tick_busy = s1_valid_q;
  assign st_o.cur_free  = !idx_end && !valid_q[cur];
  assign st_o.cur_fire  = !idx_end && fire_vec[cur];
  assign st_o.fire_any  = |fire_vec;
  assign st_o.exec_last = (n_q == LastN) || ((fire_vec & above) == '0);
  assign st_o.out_free  = out_free;

  // tick: saturating decrement, reload at zero
  assign cd_dec  = (cd_rd_q == '0) ? '0 : cd_rd_q - 1'b1;
  assign cd_hit  = (cd_dec == '0);
  assign cd_new  = cd_hit ? pr_rd_q : cd_dec;
  assign tick_wr = s1_valid_q && valid_q[s1_idx_q];

  // result fields: closing result of single-result actions, or the claimed or fired slot
  always_comb begin
    case (act_q)
      ACT_REGISTER: res_status = ST_FULL;
      ACT_DELETE,
      ACT_MODIFY:   res_status = bad_idx ? ST_BADIDX : ST_OK;
      ACT_EXECUTE:  res_status = ST_NONE;
      default:      res_status = ST_OK;
    endcase
    res_slot = '0;
    res_last = 1'b1;
    if (cmd_i.reg_claim) begin
      res_slot   = SlotW'(cur);
      res_status = ST_OK;
    end else if (cmd_i.exec_fire) begin
      res_slot   = SlotW'(cur);
      res_status = ST_FIRED;
      res_last   = st_o.exec_last;
    end
  end

  assign emit = cmd_i.reg_claim || cmd_i.exec_fire || cmd_i.resp_emit;

  // request latch, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_i;
      sidx_q   <= slot_index_i;
      delay_q  <= delay_value_i;
      reload_q <= reload_value_i;
    end
  end

  // countdown and period memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_run && !idx_end) begin
      cd_rd_q <= cd_mem[cur];
      pr_rd_q <= pr_mem[cur];
    end
    if (tick_wr) begin
      cd_mem[s1_idx_q] <= cd_new;
    end else if (cmd_i.reg_claim) begin
      cd_mem[cur] <= delay_q;
    end
    if (cmd_i.reg_claim) begin
      pr_mem[cur] <= reload_q;
    end else if (cmd_i.resp_emit && act_q == ACT_MODIFY && !bad_idx) begin
      pr_mem[sidx] <= reload_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cur;
  end

  // control state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      n_q        <= '0;
      valid_q    <= '0;
      pend_q     <= '0;
      pzero_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.tick_run && !idx_end;
      if (cmd_i.capture) begin
        idx_q <= '0;
        n_q   <= '0;
      end else if (cmd_i.adv || cmd_i.exec_fire) begin
        idx_q <= idx_q + 1'b1;
      end
      if (tick_wr && cd_hit) begin
        pend_q[s1_idx_q] <= 1'b1;
      end
      if (cmd_i.reg_claim) begin
        valid_q[cur] <= 1'b1;
        pend_q[cur]  <= 1'b0;
        pzero_q[cur] <= (reload_q == '0);
      end
      if (cmd_i.exec_fire) begin
        n_q         <= n_q + 1'b1;
        pend_q[cur] <= 1'b0;
        if (pzero_q[cur]) begin
          valid_q[cur] <= 1'b0;
        end
      end
      if (cmd_i.resp_emit && !bad_idx) begin
        if (act_q == ACT_DELETE) begin
          valid_q[sidx] <= 1'b0;
          pend_q[sidx]  <= 1'b0;
        end else if (act_q == ACT_MODIFY) begin
          pzero_q[sidx] <= (reload_q == '0);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_out_o  = out_slot_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule
